/* rtl/pfp_pkg.sv */
// Package for the pixel format packer: format codes, register indexes and the
// job record that passes from the front end to the back end through the queue.
// No dependencies.
package pfp_pkg;

	// Input component layouts.
	typedef enum logic [1:0] {
		IN_GRAY  = 2'd0,
		IN_GRAYA = 2'd1,
		IN_RGB   = 2'd2,
		IN_RGBA  = 2'd3
	} in_fmt_t;

	// Output packings. Code 3 means nothing and is reported as an error.
	typedef enum logic [1:0] {
		OUT_A4    = 2'd0,
		OUT_565   = 2'd1,
		OUT_565A8 = 2'd2
	} out_fmt_t;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_IN_FMT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_FMT = 1'b1;

	localparam logic [1:0] IN_FMT_RESET  = 2'd2;
	localparam logic [1:0] OUT_FMT_RESET = 2'd1;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam int MAX_BYTES = 3;

	// One pixel's worth of output: up to three bytes, sent byte 0 first.
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [1:0]                n_bytes;
		logic                      last;
		logic                      status;
	} job_t;

endpackage

/* rtl/pfp_pixel_if.sv */
// Pixel channel of the pixel format packer: valid/ready handshake with the
// four components and the end-of-image flag. No dependencies.
interface pfp_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] comp0;
	logic [7:0] comp1;
	logic [7:0] comp2;
	logic [7:0] comp3;
	logic       last_pixel;

	modport source (output valid, comp0, comp1, comp2, comp3, last_pixel, input ready);
	modport sink (input valid, comp0, comp1, comp2, comp3, last_pixel, output ready);
endinterface

/* rtl/pfp_byte_if.sv */
// Byte channel of the pixel format packer: valid/ready handshake with one
// packed byte, its end-of-image flag and its status. No dependencies.
interface pfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_byte;
	logic       status;

	modport source (output valid, out_byte, last_byte, status, input ready);
	modport sink (input valid, out_byte, last_byte, status, output ready);
endinterface

/* rtl/pfp_front.sv */
// Front end of the pixel format packer: holds the format registers and the A4
// nibble state, and turns each accepted pixel into a job. Uses pfp_pkg, pfp_pixel_if.
module pfp_front (
	input  logic                         clk,
	input  logic                         arst_n,
	pfp_pixel_if.sink                    pixel,
	input  logic                         cfg_we,
	input  logic [pfp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [pfp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                         q_full,
	output logic                         push,
	output pfp_pkg::job_t                push_job
);
	import pfp_pkg::*;

	logic [1:0] in_fmt_q;
	logic [1:0] out_fmt_q;
	logic [3:0] held_nibble_q;
	logic       nibble_pending_q;

	logic       accept;
	logic       gray_in;
	logic       has_job;
	logic       hold_nibble;
	logic [15:0] word;
	logic [7:0]  alpha;
	job_t        job;

	assign pixel.ready = !q_full;
	assign accept      = pixel.valid && pixel.ready;
	assign gray_in     = (in_fmt_q == IN_GRAY) || (in_fmt_q == IN_GRAYA);
	assign word        = {pixel.comp0[7:3], pixel.comp1[7:2], pixel.comp2[7:3]};
	assign alpha       = (in_fmt_q == IN_RGBA) ? pixel.comp3 : ALPHA_OPAQUE;

	always_comb begin
		job         = '0;
		job.n_bytes = 2'd1;
		job.last    = pixel.last_pixel;
		has_job     = 1'b1;
		hold_nibble = 1'b0;
		unique case (out_fmt_q) inside
			OUT_A4: begin
				if (!gray_in) begin
					job.status = 1'b1;
				end else if (nibble_pending_q) begin
					job.bytes[0] = {held_nibble_q, pixel.comp0[7:4]};
				end else if (pixel.last_pixel) begin
					// Odd pixel count: flush with an empty low nibble.
					job.bytes[0] = {pixel.comp0[7:4], 4'h0};
				end else begin
					has_job     = 1'b0;
					hold_nibble = 1'b1;
				end
			end
			OUT_565, OUT_565A8: begin
				if (gray_in) begin
					job.status = 1'b1;
				end else begin
					job.bytes[0] = word[7:0];
					job.bytes[1] = word[15:8];
					job.bytes[2] = alpha;
					job.n_bytes  = (out_fmt_q == OUT_565A8) ? 2'd3 : 2'd2;
				end
			end
			default: begin
				job.status = 1'b1;
			end
		endcase
	end

	assign push     = accept && has_job;
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_fmt_q  <= IN_FMT_RESET;
			out_fmt_q <= OUT_FMT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_IN_FMT:  in_fmt_q  <= cfg_wdata;
				CFG_OUT_FMT: out_fmt_q <= cfg_wdata;
			endcase
		end
	end

	// Any pixel that does not start an A4 pair drops the held nibble.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_nibble_q    <= '0;
			nibble_pending_q <= 1'b0;
		end else if (accept) begin
			nibble_pending_q <= hold_nibble;
			held_nibble_q    <= hold_nibble ? pixel.comp0[7:4] : 4'h0;
		end
	end

	a_pair_completes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && nibble_pending_q && out_fmt_q == OUT_A4 && gray_in |-> push)
		else $error("second A4 pixel of a pair produced no byte");

endmodule

/* rtl/pfp_queue.sv */
// Short job queue between the front and back ends of the pixel format packer.
// Uses pfp_pkg.
module pfp_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pfp_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output pfp_pkg::job_t pop_job
);
	import pfp_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	job_t          entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_job   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("job popped from an empty queue");

endmodule

/* rtl/pfp_back.sv */
// Back end of the pixel format packer: takes jobs from the queue and sends their bytes
// one per cycle unless the output stalls, via an output register. Uses pfp_pkg, pfp_byte_if.
module pfp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_not_empty,
	input  pfp_pkg::job_t q_job,
	output logic          pop,
	pfp_byte_if.source    stream
);
	import pfp_pkg::*;

	job_t       job_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       status_q;

	logic       advance;
	logic       emit;
	logic       last_idx;
	logic       finish;
	logic [7:0] sel_byte;

	assign advance  = !out_valid_q || stream.ready;
	assign emit     = busy_q && advance;
	assign last_idx = (idx_q == job_q.n_bytes - 2'd1);
	assign finish   = emit && last_idx;
	assign pop      = q_not_empty && (!busy_q || finish);

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = job_q.bytes[0];
			2'd1:    sel_byte = job_q.bytes[1];
			default: sel_byte = job_q.bytes[2];
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_job;
		end
		if (emit) begin
			byte_q   <= sel_byte;
			last_q   <= last_idx && job_q.last;
			status_q <= job_q.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (finish) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
			end
			if (advance) begin
				out_valid_q <= busy_q;
			end
		end
	end

	assign stream.valid     = out_valid_q;
	assign stream.out_byte  = byte_q;
	assign stream.last_byte = last_q;
	assign stream.status    = status_q;

	a_error_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q |-> byte_q == 8'h00)
		else $error("error result carries a non-zero byte");

	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < job_q.n_bytes)
		else $error("byte index ran past the end of the job");

endmodule

/* rtl/pixel_format_packer_top.sv */
// Top level of the pixel format packer: front end, job queue and back end.
// Uses pfp_pkg, pfp_pixel_if, pfp_byte_if, pfp_front, pfp_queue, pfp_back.
//
//   Channel   Direction  Handshake           Carries
//   pixel     in         valid/ready         comp0..comp3, last_pixel
//   stream    out        valid/ready         out_byte, last_byte, status
//   cfg       in         cfg_we, no ready    cfg_idx (0 input, 1 output), cfg_wdata
//
// The output sends one byte per cycle while it is not stalled. A pixel yields one
// byte for A4 and error results, none for the first pixel of an A4 pair, two for
// RGB565 and three for RGB565 plus alpha. The first byte of a pixel passes through
// the queue, the back end's job register and the output register before it appears.
// Reset clears the format registers to RGB in, RGB565 out, and drops any nibble.
// pixel.ready is low exactly while the queue is full: under an output stall, or when
// pixels that yield two or three bytes arrive faster than the back end drains them.
module pixel_format_packer_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	pfp_pixel_if.sink                      pixel,
	pfp_byte_if.source                     stream,
	input  logic                           cfg_we,
	input  logic [pfp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [pfp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import pfp_pkg::*;

	// Request path: the front end classifies each pixel and, when it has bytes to send,
	// writes one job; the back end drains jobs at one byte per cycle unless stalled.
	logic q_full;
	logic q_not_empty;
	logic push;
	logic pop;
	job_t push_job;
	job_t pop_job;

	pfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job)
	);

	// The queue lets a new pixel enter while a three-byte result is still draining.
	pfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.pop_job   (pop_job)
	);

	pfp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_job       (pop_job),
		.pop         (pop),
		.stream      (stream)
	);

endmodule
